[sv/pbmd_pkg.sv]
`timescale 1ns / 1ps
// shared constants and types for the point-to-box minimum distance core
// no dependencies

package pbmd_pkg;

	// default coordinate width, signed fixed point
	localparam int COORD_WIDTH_DEF = 24;

	// side flags that travel with each beat down the pipeline
	typedef struct packed {
		logic valid;
		logic in_box;
	} pbmd_flags_t;

endpackage

[sv/pbmd_front.sv]
`timescale 1ns / 1ps
// front end: per-axis gaps, squares and their sum over three register stages
// depends on pbmd_pkg

module pbmd_front
	import pbmd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          src_valid,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] box_x_min,
	input  logic signed [COORD_WIDTH-1:0] box_x_max,
	input  logic signed [COORD_WIDTH-1:0] box_y_min,
	input  logic signed [COORD_WIDTH-1:0] box_y_max,
	output logic [2*COORD_WIDTH:0]        sum_s3,
	output pbmd_flags_t                   flags_s3
);

	localparam int CW = COORD_WIDTH;

	logic signed [CW:0]   dx_lo, dx_hi, dy_lo, dy_hi;
	logic                 x_below, x_above, y_below, y_above;
	logic [CW-1:0]        gap_x, gap_y;

	logic [CW-1:0]        gap_x_s1, gap_y_s1;
	pbmd_flags_t          flags_s1, flags_s2;
	logic [2*CW-1:0]      sqx_s2, sqy_s2;

	// gap to the nearer edge, zero within the interval
	always_comb begin
		x_below = point_x < box_x_min;
		x_above = point_x > box_x_max;
		y_below = point_y < box_y_min;
		y_above = point_y > box_y_max;
		dx_lo   = (CW+1)'(box_x_min) - (CW+1)'(point_x);
		dx_hi   = (CW+1)'(point_x) - (CW+1)'(box_x_max);
		dy_lo   = (CW+1)'(box_y_min) - (CW+1)'(point_y);
		dy_hi   = (CW+1)'(point_y) - (CW+1)'(box_y_max);
		if (x_below) begin
			gap_x = dx_lo[CW-1:0];
		end else if (x_above) begin
			gap_x = dx_hi[CW-1:0];
		end else begin
			gap_x = '0;
		end
		if (y_below) begin
			gap_y = dy_lo[CW-1:0];
		end else if (y_above) begin
			gap_y = dy_hi[CW-1:0];
		end else begin
			gap_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
			flags_s2 <= '0;
			flags_s3 <= '0;
		end else if (en) begin
			flags_s1.valid  <= src_valid;
			flags_s1.in_box <= !x_below && !x_above && !y_below && !y_above;
			flags_s2        <= flags_s1;
			flags_s3        <= flags_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gap_x_s1 <= gap_x;
			gap_y_s1 <= gap_y;
			sqx_s2   <= (2*CW)'(gap_x_s1) * (2*CW)'(gap_x_s1);
			sqy_s2   <= (2*CW)'(gap_y_s1) * (2*CW)'(gap_y_s1);
			sum_s3   <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
		end
	end

endmodule

[sv/pbmd_isqrt.sv]
`timescale 1ns / 1ps
// pipelined floor square root, one root bit per register stage
// depends on pbmd_pkg

module pbmd_isqrt
	import pbmd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [2*COORD_WIDTH:0] radicand,
	input  pbmd_flags_t            flags_in,
	output logic [COORD_WIDTH:0]   root,
	output pbmd_flags_t            flags_out
);

	localparam int R  = COORD_WIDTH + 1;
	localparam int RN = 2 * R;

	logic [RN-1:0]  rad_s   [0:R];
	logic [R+1:0]   rem_s   [0:R];
	logic [R-1:0]   root_s  [0:R];
	pbmd_flags_t    flags_s [0:R];

	assign rad_s[0]   = {1'b0, radicand};
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign flags_s[0] = flags_in;

	for (genvar k = 0; k < R; k++) begin : g_step
		logic [R+3:0] rem_sh;
		logic [R+3:0] trial;
		logic [R+3:0] diff;
		logic         fits;

		// bring down the next bit pair and try root*4+1
		always_comb begin
			rem_sh = {rem_s[k], rad_s[k][2*(R-1-k)+1 -: 2]};
			trial  = {2'b00, root_s[k], 2'b01};
			diff   = rem_sh - trial;
			fits   = rem_sh >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_s[k+1] <= '0;
			end else if (en) begin
				flags_s[k+1] <= flags_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k+1]  <= rad_s[k];
				root_s[k+1] <= {root_s[k][R-2:0], fits};
				rem_s[k+1]  <= fits ? diff[R+1:0] : rem_sh[R+1:0];
			end
		end
	end

	assign root      = root_s[R];
	assign flags_out = flags_s[R];

endmodule

[sv/point_box_min_distance_core.sv]
`timescale 1ns / 1ps
// top level: point-to-box minimum distance (r-tree mindist), fixed point
// depends on pbmd_pkg, pbmd_front, pbmd_isqrt
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------------
//  input   | in_valid / in_stall | point_x, point_y, box_x_min/max, box_y_min/max
//  output  | out_valid/out_stall | min_distance, point_inside
//
// one beat enters per cycle unless the output beat is stalled; a beat passes
// three front stages (gap, square, sum) and one square-root stage per
// root bit. in_stall comes from a one-entry input skid register, so it is a
// flop output. the whole pipeline holds while the output beat is stalled;
// a beat that arrives in that cycle parks in the skid register.
// reset clears the valid and in-box flags and the skid flag only.

module point_box_min_distance_core
	import pbmd_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] box_x_min,
	input  logic signed [COORD_WIDTH-1:0] box_x_max,
	input  logic signed [COORD_WIDTH-1:0] box_y_min,
	input  logic signed [COORD_WIDTH-1:0] box_y_max,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [COORD_WIDTH:0]          min_distance,
	output logic                          point_inside
);

	localparam int CW = COORD_WIDTH;

	// pipeline advance: everything moves unless the output beat is held
	logic en;

	// input skid register
	logic                 skid_v_q;
	logic signed [CW-1:0] skid_px_q, skid_py_q;
	logic signed [CW-1:0] skid_xmin_q, skid_xmax_q, skid_ymin_q, skid_ymax_q;

	// beat presented to the first stage
	logic                 src_valid;
	logic signed [CW-1:0] src_px, src_py, src_xmin, src_xmax, src_ymin, src_ymax;

	logic [2*CW:0]        sum_s3;
	pbmd_flags_t          flags_s3;
	pbmd_flags_t          flags_out;

	assign en       = !(out_valid && out_stall);
	assign in_stall = skid_v_q;

	// a parked beat goes first; input is stalled while it is there
	always_comb begin
		src_valid = skid_v_q || in_valid;
		if (skid_v_q) begin
			src_px   = skid_px_q;
			src_py   = skid_py_q;
			src_xmin = skid_xmin_q;
			src_xmax = skid_xmax_q;
			src_ymin = skid_ymin_q;
			src_ymax = skid_ymax_q;
		end else begin
			src_px   = point_x;
			src_py   = point_y;
			src_xmin = box_x_min;
			src_xmax = box_x_max;
			src_ymin = box_y_min;
			src_ymax = box_y_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (en) begin
			skid_v_q <= 1'b0;
		end else if (in_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	// capture the accepted beat while the pipeline is held
	always_ff @(posedge clk) begin
		if (!en && in_valid && !skid_v_q) begin
			skid_px_q   <= point_x;
			skid_py_q   <= point_y;
			skid_xmin_q <= box_x_min;
			skid_xmax_q <= box_x_max;
			skid_ymin_q <= box_y_min;
			skid_ymax_q <= box_y_max;
		end
	end

	// gaps, squares, sum of squares
	pbmd_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (src_valid),
		.point_x   (src_px),
		.point_y   (src_py),
		.box_x_min (src_xmin),
		.box_x_max (src_xmax),
		.box_y_min (src_ymin),
		.box_y_max (src_ymax),
		.sum_s3    (sum_s3),
		.flags_s3  (flags_s3)
	);

	// floor root of the squared distance; last stage is the output register
	pbmd_isqrt #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.radicand  (sum_s3),
		.flags_in  (flags_s3),
		.root      (min_distance),
		.flags_out (flags_out)
	);

	assign out_valid    = flags_out.valid;
	assign point_inside = flags_out.in_box;

endmodule

[tb/tb_point_box_min_distance_core.sv]
`timescale 1ns / 1ps
// self-checking bench for point_box_min_distance_core: directed corner cases, then
// random point/box pairs under three idle patterns, checked against a local predictor
// depends on pbmd_pkg and point_box_min_distance_core

module tb_point_box_min_distance_core;
	import pbmd_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [CW:0] dist_t;

	// one input beat: a point and the four box edges
	typedef struct {
		coord_t px;
		coord_t py;
		coord_t xmin;
		coord_t xmax;
		coord_t ymin;
		coord_t ymax;
	} point_box_t;

	// one predicted output beat
	typedef struct {
		dist_t dist_val;
		logic  in_box;
	} mindist_t;

	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t ONE   = coord_t'(256);	// 1.0 with 8 fractional bits

	localparam int N_RANDOM_PER_PHASE = 330;
	localparam int N_PHASES           = 3;
	localparam int DRAIN_CYCLES       = 40;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_stall;
	coord_t point_x;
	coord_t point_y;
	coord_t box_x_min;
	coord_t box_x_max;
	coord_t box_y_min;
	coord_t box_y_max;
	logic   out_valid;
	logic   out_stall;
	dist_t  min_distance;
	logic   point_inside;

	// percent of cycles in which each side holds off
	int src_idle_pct;
	int sink_idle_pct;

	// ---------------------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------------------

	// distance from p to the interval [lo, hi] along one axis; for a malformed
	// interval (lo > hi) the low edge is tested first, the way the block clamps
	function automatic longint unsigned axis_gap_len(coord_t p, coord_t lo, coord_t hi);
		if (p < lo)
			return longint'(lo) - longint'(p);
		if (p > hi)
			return longint'(p) - longint'(hi);
		return 0;
	endfunction

	// floor square root, settled one root bit at a time from the top;
	// the sum of two squared 24-bit gaps stays below 2^50, so 26 root bits are plenty
	function automatic dist_t floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = CW + 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v)
				root = trial;
		end
		return dist_t'(root);
	endfunction

	function automatic mindist_t predict_mindist(point_box_t pb);
		mindist_t        r;
		longint unsigned gx;
		longint unsigned gy;
		gx = axis_gap_len(pb.px, pb.xmin, pb.xmax);
		gy = axis_gap_len(pb.py, pb.ymin, pb.ymax);
		r.dist_val = floor_root(gx * gx + gy * gy);
		// a malformed axis can never hold the point, so this stays 0 there
		r.in_box   = (pb.px >= pb.xmin) && (pb.px <= pb.xmax) &&
			(pb.py >= pb.ymin) && (pb.py <= pb.ymax);
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// scoreboard: in-order queue of predicted distances
	// ---------------------------------------------------------------------------

	class mindist_scoreboard;
		mindist_t expected_q[$];
		int       mismatches;

		function new();
			mismatches = 0;
		endfunction

		task report_mismatch(string msg);
			// keep the log short when everything goes wrong
			if (mismatches < 50)
				$display("[%0t] mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		function void note_point_box(point_box_t pb);
			expected_q.push_back(predict_mindist(pb));
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		task check_result(dist_t dist_val, logic in_box);
			mindist_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: min_distance %0d point_inside %b",
					dist_val, in_box));
				return;
			end
			want = expected_q.pop_front();
			if (dist_val !== want.dist_val)
				report_mismatch($sformatf("min_distance %0d, expected %0d", dist_val,
					want.dist_val));
			if (in_box !== want.in_box)
				report_mismatch($sformatf("point_inside %b, expected %b", in_box, want.in_box));
		endtask
	endclass

	mindist_scoreboard sb;

	// ---------------------------------------------------------------------------
	// device under test
	// ---------------------------------------------------------------------------

	point_box_min_distance_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.point_x      (point_x),
		.point_y      (point_y),
		.box_x_min    (box_x_min),
		.box_x_max    (box_x_max),
		.box_y_min    (box_y_min),
		.box_y_max    (box_y_max),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.min_distance (min_distance),
		.point_inside (point_inside)
	);

	// 8 ns clock
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------------------

	function automatic point_box_t pb_of(coord_t px, coord_t py, coord_t xmin, coord_t xmax,
		coord_t ymin, coord_t ymax);
		point_box_t pb;
		pb.px   = px;
		pb.py   = py;
		pb.xmin = xmin;
		pb.xmax = xmax;
		pb.ymin = ymin;
		pb.ymax = ymax;
		return pb;
	endfunction

	// whole units in the fixed-point format
	function automatic coord_t units(int n);
		return coord_t'(n * int'(ONE));
	endfunction

	// coordinates from several magnitude bands so both huge and tiny gaps show up
	function automatic coord_t rand_coord();
		case ($urandom_range(0, 3))
			0: return coord_t'($urandom);
			1: return coord_t'(int'($urandom_range(0, 8191)) - 4096);
			2: begin
				case ($urandom_range(0, 3))
					0: return C_MIN;
					1: return C_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return coord_t'($urandom) >>> $urandom_range(0, 20);
		endcase
	endfunction

	// place a coordinate relative to [lo, hi]: anywhere, within, on an edge or just past one
	function automatic coord_t rand_axis_point(coord_t lo, coord_t hi);
		longint span;
		span = longint'(hi) - longint'(lo);
		case ($urandom_range(0, 4))
			0: return rand_coord();
			1: begin
				if (span < 0)
					return rand_coord();
				return coord_t'(longint'(lo) + longint'($urandom) % (span + 1));
			end
			2: return $urandom_range(0, 1) ? lo : hi;
			3: return coord_t'(lo - coord_t'($urandom_range(1, 600)));
			default: return coord_t'(hi + coord_t'($urandom_range(1, 600)));
		endcase
	endfunction

	// mostly well-formed boxes; about one axis in eight comes out malformed
	function automatic point_box_t rand_point_box();
		point_box_t pb;
		coord_t     a;
		coord_t     b;
		a = rand_coord();
		b = $urandom_range(0, 1) ? rand_coord() : coord_t'(a + coord_t'($urandom_range(0, 4095)));
		pb.xmin = (a <= b) ? a : b;
		pb.xmax = (a <= b) ? b : a;
		if ($urandom_range(0, 7) == 0) begin
			pb.xmin = (a <= b) ? b : a;
			pb.xmax = (a <= b) ? a : b;
		end
		a = rand_coord();
		b = $urandom_range(0, 1) ? rand_coord() : coord_t'(a + coord_t'($urandom_range(0, 4095)));
		pb.ymin = (a <= b) ? a : b;
		pb.ymax = (a <= b) ? b : a;
		if ($urandom_range(0, 7) == 0) begin
			pb.ymin = (a <= b) ? b : a;
			pb.ymax = (a <= b) ? a : b;
		end
		pb.px = rand_axis_point(pb.xmin, pb.xmax);
		pb.py = rand_axis_point(pb.ymin, pb.ymax);
		return pb;
	endfunction

	// send one beat: optional idle cycles first, then hold the payload until taken;
	// everything changes on the falling edge, acceptance is seen on the rising edge
	task automatic send_point_box(point_box_t pb);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid  = 1'b1;
		point_x   = pb.px;
		point_y   = pb.py;
		box_x_min = pb.xmin;
		box_x_max = pb.xmax;
		box_y_min = pb.ymin;
		box_y_max = pb.ymax;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_point_box(pb);
	endtask

	// hold off the sender until every predicted beat has come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------------
	// receiver: random stall on the falling edge, check on the rising edge
	// ---------------------------------------------------------------------------

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(0, 99) < sink_idle_pct);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result(min_distance, point_inside);
		end
	end

	// ---------------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------------

	initial begin
		point_box_t directed_q[$];

		sb            = new();
		src_idle_pct  = 38;
		sink_idle_pct = 46;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		point_x       = '0;
		point_y       = '0;
		box_x_min     = '0;
		box_x_max     = '0;
		box_y_min     = '0;
		box_y_max     = '0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// degenerate box at the origin with the point on it
		directed_q.push_back(pb_of('0, '0, '0, '0, '0, '0));
		// point strictly inside
		directed_q.push_back(pb_of(ONE, ONE, '0, units(4), '0, units(4)));
		// point on the left edge, on the right edge, on a corner
		directed_q.push_back(pb_of('0, units(2), '0, units(4), '0, units(4)));
		directed_q.push_back(pb_of(units(4), units(2), '0, units(4), '0, units(4)));
		directed_q.push_back(pb_of(units(4), units(4), '0, units(4), '0, units(4)));
		// straight gaps beside each edge of the box
		directed_q.push_back(pb_of(units(-3), units(2), '0, units(4), '0, units(4)));
		directed_q.push_back(pb_of(units(7), units(2), '0, units(4), '0, units(4)));
		directed_q.push_back(pb_of(units(2), units(-5), '0, units(4), '0, units(4)));
		directed_q.push_back(pb_of(units(2), units(9), '0, units(4), '0, units(4)));
		// diagonal region, 3-4-5 triangle to the lower-left corner
		directed_q.push_back(pb_of(units(-3), units(-4), '0, units(4), '0, units(4)));
		// one-lsb gaps: straight and diagonal (root of 2 floors to 1)
		directed_q.push_back(pb_of(coord_t'(-1), '0, '0, ONE, '0, ONE));
		directed_q.push_back(pb_of(coord_t'(ONE + 1), coord_t'(ONE + 1), '0, ONE, '0, ONE));
		// a gap that is not a perfect square
		directed_q.push_back(pb_of(coord_t'(-7), coord_t'(-11), '0, ONE, '0, ONE));
		// widest gaps on both axes, point and box at opposite extremes
		directed_q.push_back(pb_of(C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX));
		directed_q.push_back(pb_of(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN));
		directed_q.push_back(pb_of(C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX));
		// full-range box holds any point, extremes included
		directed_q.push_back(pb_of(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX));
		directed_q.push_back(pb_of(C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX));
		// malformed x axis: point between the swapped edges, then past each of them
		directed_q.push_back(pb_of('0, ONE, coord_t'(10), coord_t'(-10), '0, units(2)));
		directed_q.push_back(pb_of(coord_t'(20), ONE, coord_t'(10), coord_t'(-10), '0,
			units(2)));
		directed_q.push_back(pb_of(coord_t'(-20), ONE, coord_t'(10), coord_t'(-10), '0,
			units(2)));
		// malformed on both axes, swapped edges at the extremes
		directed_q.push_back(pb_of('0, '0, C_MAX, C_MIN, C_MAX, C_MIN));
		directed_q.push_back(pb_of(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN));

		foreach (directed_q[i])
			send_point_box(directed_q[i]);

		// random part under three idle patterns
		for (int phase = 0; phase < N_PHASES; phase++) begin
			case (phase)
				0: begin
					src_idle_pct  = 38;
					sink_idle_pct = 46;
				end
				1: begin
					src_idle_pct  = 46;
					sink_idle_pct = 38;
				end
				default: begin
					src_idle_pct  = 0;
					sink_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < N_RANDOM_PER_PHASE; n++) begin
				// mid-phase the sender waits for the pipeline to run empty
				if (n == N_RANDOM_PER_PHASE / 2)
					wait_drained();
				send_point_box(rand_point_box());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb_point_box_min_distance_core OK");
		else
			$display("tb_point_box_min_distance_core NOT OK");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("tb_point_box_min_distance_core NOT OK");
		$finish;
	end

endmodule

[point_box_min_distance_core.f]
sv/pbmd_pkg.sv
sv/pbmd_front.sv
sv/pbmd_isqrt.sv
sv/point_box_min_distance_core.sv
tb/tb_point_box_min_distance_core.sv
